// ----- sv/plist_pkg.sv -----
package plist_pkg;

  localparam int DATA_W = 32;
  localparam int OP_W   = 2;
  localparam int POS_W  = 5;
  localparam int ST_W   = 3;
  localparam int LEN_W  = 5;

  localparam logic [OP_W-1:0] OP_INSERT  = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE  = 2'd1;
  localparam logic [OP_W-1:0] OP_DISPLAY = 2'd2;

  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_BADPOS    = 3'd1;
  localparam logic [ST_W-1:0] ST_UNDERFLOW = 3'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

endpackage

// ----- sv/plist_ram.sv -----
module plist_ram import plist_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_i,
  output logic [DATA_W-1:0] rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- sv/positional_list_insert_delete_core.sv -----
// Results: an error result is registered and shows in the cycle after the transaction is
//   accepted; an insert or a delete reports once its shift loop is done, and a display
//   shows its elements one per cycle.
// Throughput: one transaction at a time, paced by the shift loop through the element RAM
//   (one entry moved per cycle); a new start is taken while the last result shows.
//   The receiver cannot stall results.
// Reset: asynchronous, active low; clears the element count and control, RAM untouched.
module positional_list_insert_delete_core import plist_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start,
  output logic                     busy,
  input  logic [OP_W-1:0]          operation_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     strobe_o,
  output logic [ST_W-1:0]          status_o,
  output logic signed [DATA_W-1:0] data_o,
  output logic [LEN_W-1:0]         length_o,
  output logic                     last_o
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  // compare width: room for count+2 and for the position field
  localparam int XW = ((CW > POS_W) ? CW : POS_W) + 2;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_INS_WR  = 3'd1;  // shift one entry up per cycle
  localparam logic [2:0] S_INS_PUT = 3'd2;  // drop new value into the hole
  localparam logic [2:0] S_DEL_CAP = 3'd3;  // capture the removed value
  localparam logic [2:0] S_DEL_WR  = 3'd4;  // shift one entry down per cycle
  localparam logic [2:0] S_DISP    = 3'd5;  // stream elements out

  logic [2:0]        state_q, state_d;
  logic [CW-1:0]     count_q, count_d;
  logic [AW-1:0]     cur_q, cur_d;
  logic              strobe_q, strobe_d;

  // payload registers, no reset needed
  logic [AW-1:0]     pm1_q, pm1_d;
  logic [DATA_W-1:0] val_q, val_d;
  logic [DATA_W-1:0] removed_q, removed_d;
  logic [ST_W-1:0]   status_q, status_d;
  logic [DATA_W-1:0] data_q, data_d;
  logic [LEN_W-1:0]  length_q, length_d;
  logic              last_q, last_d;

  // RAM port
  logic              ram_we, ram_re;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_wdata, ram_rdata;

  logic [XW-1:0]     posx, cntx, curx, pm1x;

  assign posx = XW'(position_i);
  assign cntx = XW'(count_q);
  assign curx = XW'(cur_q);
  assign pm1x = XW'(pm1_q);

  plist_ram #(
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    pm1_d     = pm1_q;
    val_d     = val_q;
    removed_d = removed_q;
    strobe_d  = 1'b0;
    status_d  = status_q;
    data_d    = data_q;
    length_d  = length_q;
    last_d    = last_q;
    ram_we    = 1'b0;
    ram_waddr = cur_q;
    ram_wdata = ram_rdata;
    ram_re    = 1'b0;
    ram_raddr = cur_q;

    case (state_q)
      S_IDLE: begin
        if (start) begin
          // default result: error, no change, single transaction
          status_d = ST_BADPOS;
          data_d   = '0;
          length_d = LEN_W'(count_q);
          last_d   = 1'b1;
          case (operation_i)
            OP_INSERT: begin
              if (posx == '0 || posx > cntx + 1'b1) begin
                strobe_d = 1'b1;
              end else if (cntx >= XW'(CAPACITY)) begin
                strobe_d = 1'b1;
                status_d = ST_FULL;
              end else begin
                val_d = value_i;
                pm1_d = AW'(posx - 1'b1);
                if (cntx >= posx) begin
                  // tail entry moves first
                  ram_re    = 1'b1;
                  ram_raddr = AW'(cntx - 1'b1);
                  cur_d     = AW'(cntx);
                  state_d   = S_INS_WR;
                end else begin
                  state_d = S_INS_PUT;
                end
              end
            end
            OP_DELETE: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_UNDERFLOW;
              end else if (posx == '0 || posx > cntx) begin
                strobe_d = 1'b1;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(posx - 1'b1);
                cur_d     = AW'(posx - 1'b1);
                state_d   = S_DEL_CAP;
              end
            end
            OP_DISPLAY: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_EMPTY;
              end else begin
                ram_re    = 1'b1;
                ram_raddr = '0;
                cur_d     = '0;
                state_d   = S_DISP;
              end
            end
            default: begin
              strobe_d = 1'b1;
            end
          endcase
        end
      end

      S_INS_WR: begin
        // entry cur-1 arrived: store it one place up, fetch the next lower one
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = ram_rdata;
        if (curx > pm1x + 1'b1) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(curx - 2'd2);
          cur_d     = AW'(curx - 1'b1);
        end else begin
          state_d = S_INS_PUT;
        end
      end

      S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = pm1_q;
        ram_wdata = val_q;
        count_d   = CW'(count_q + 1'b1);
        strobe_d  = 1'b1;
        status_d  = ST_OK;
        data_d    = val_q;
        length_d  = LEN_W'(cntx + 1'b1);
        last_d    = 1'b1;
        state_d   = S_IDLE;
      end

      S_DEL_CAP: begin
        removed_d = ram_rdata;
        if (curx + 1'b1 < cntx) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(curx + 1'b1);
          state_d   = S_DEL_WR;
        end else begin
          // removed the tail: nothing to close up
          count_d  = CW'(count_q - 1'b1);
          strobe_d = 1'b1;
          status_d = ST_OK;
          data_d   = ram_rdata;
          length_d = LEN_W'(cntx - 1'b1);
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_DEL_WR: begin
        // entry cur+1 arrived: store it one place down, fetch cur+2
        ram_we    = 1'b1;
        ram_waddr = cur_q;
        ram_wdata = ram_rdata;
        cur_d     = AW'(curx + 1'b1);
        if (curx + 2'd2 < cntx) begin
          ram_re    = 1'b1;
          ram_raddr = AW'(curx + 2'd2);
        end else begin
          count_d  = CW'(count_q - 1'b1);
          strobe_d = 1'b1;
          status_d = ST_OK;
          data_d   = removed_q;
          length_d = LEN_W'(cntx - 1'b1);
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_DISP: begin
        strobe_d = 1'b1;
        status_d = ST_OK;
        data_d   = ram_rdata;
        length_d = LEN_W'(count_q);
        last_d   = (curx + 1'b1 == cntx);
        if (curx + 1'b1 == cntx) begin
          state_d = S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = AW'(curx + 1'b1);
          cur_d     = AW'(curx + 1'b1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      cur_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      cur_q    <= cur_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pm1_q     <= pm1_d;
    val_q     <= val_d;
    removed_q <= removed_d;
    status_q  <= status_d;
    data_q    <= data_d;
    length_q  <= length_d;
    last_q    <= last_d;
  end

  assign busy     = (state_q != S_IDLE);
  assign strobe_o = strobe_q;
  assign status_o = status_q;
  assign data_o   = data_q;
  assign length_o = length_q;
  assign last_o   = last_q;

  // every accepted transaction either starts work or reports at once
  a_accept_progress: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy || strobe_o)
    else $error("accepted transaction produced neither work nor a result");

  // error results are single, final and carry zero data
  a_error_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && status_o != ST_OK |-> last_o && data_o == '0)
    else $error("error result not final or data nonzero");

  // a non-final display element means streaming continues
  a_display_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    strobe_o && !last_o |-> busy && state_q == S_DISP)
    else $error("non-final result without display in progress");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    XW'(count_q) <= XW'(CAPACITY))
    else $error("element count above capacity");

  // shift loops never read and write the same entry in one cycle
  a_no_rw_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("RAM read and write at same address");

endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import plist_pkg::*;

  localparam int CLK_PERIOD   = 20;
  localparam int LIST_CAP     = 16;
  localparam int RANDOM_ITEMS = 405;
  // Far above the slowest legal run.
  localparam int WATCHDOG_NS  = 5_000_000;

  // The package leaves the spare code unnamed; the block treats it as a bad position.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  // One result as seen on the output ports.
  typedef struct packed {
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } list_result_t;

  // Directed row. With typed set, the single result is spelled out here;
  // otherwise the list model supplies it.
  typedef struct packed {
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;
    logic                     typed;
    logic [ST_W-1:0]          status;
    logic signed [DATA_W-1:0] data;
    logic [LEN_W-1:0]         length;
  } directed_row_t;

  localparam int N_DIRECTED = 25;

  // Walks the empty-list errors, the unused opcode, both value extremes, middle and end
  // inserts, out-of-range positions on both sides, and drains back to empty.
  localparam directed_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{OP_DISPLAY, 5'd0,  32'sh0000_0000, 1'b1, ST_EMPTY,     32'sh0000_0000, 5'd0},
    '{OP_DELETE,  5'd1,  32'sh0000_0000, 1'b1, ST_UNDERFLOW, 32'sh0000_0000, 5'd0},
    // underflow wins over a bad position
    '{OP_DELETE,  5'd0,  32'shFFFF_FFFF, 1'b1, ST_UNDERFLOW, 32'sh0000_0000, 5'd0},
    '{OP_INSERT,  5'd0,  32'sh1234_5678, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd0},
    '{OP_INSERT,  5'd2,  32'sh0000_0001, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd0},
    '{OP_UNUSED,  5'd0,  32'sh0000_0000, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd0},
    '{OP_INSERT,  5'd1,  32'sh8000_0000, 1'b1, ST_OK,        32'sh8000_0000, 5'd1},
    '{OP_INSERT,  5'd2,  32'sh7FFF_FFFF, 1'b1, ST_OK,        32'sh7FFF_FFFF, 5'd2},
    '{OP_INSERT,  5'd1,  32'shFFFF_FFFF, 1'b1, ST_OK,        32'shFFFF_FFFF, 5'd3},
    '{OP_INSERT,  5'd2,  32'sh0000_0000, 1'b1, ST_OK,        32'sh0000_0000, 5'd4},
    '{OP_DISPLAY, 5'd0,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_DELETE,  5'd0,  32'sh0000_0000, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd4},
    '{OP_DELETE,  5'd5,  32'sh0000_0000, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd4},
    '{OP_INSERT,  5'd6,  32'sh0000_0000, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd4},
    '{OP_INSERT,  5'd31, 32'shFFFF_FFFF, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd4},
    '{OP_DELETE,  5'd4,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_DELETE,  5'd1,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_UNUSED,  5'd31, 32'shFFFF_FFFF, 1'b1, ST_BADPOS,    32'sh0000_0000, 5'd2},
    '{OP_DISPLAY, 5'd0,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_INSERT,  5'd3,  32'sh5555_AAAA, 1'b1, ST_OK,        32'sh5555_AAAA, 5'd3},
    '{OP_DELETE,  5'd2,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_DELETE,  5'd1,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_DELETE,  5'd1,  32'sh0000_0000, 1'b0, ST_OK,        32'sh0000_0000, 5'd0},
    '{OP_DELETE,  5'd1,  32'sh0000_0000, 1'b1, ST_UNDERFLOW, 32'sh0000_0000, 5'd0},
    '{OP_DISPLAY, 5'd0,  32'sh0000_0000, 1'b1, ST_EMPTY,     32'sh0000_0000, 5'd0}
  };

  // DUT-facing signals; the ones the bench drives are known from time zero.
  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     start       = 1'b0;
  logic                     busy;
  logic [OP_W-1:0]          operation_i = OP_INSERT;
  logic [POS_W-1:0]         position_i  = '0;
  logic signed [DATA_W-1:0] value_i     = '0;
  logic                     strobe_o;
  logic [ST_W-1:0]          status_o;
  logic signed [DATA_W-1:0] data_o;
  logic [LEN_W-1:0]         length_o;
  logic                     last_o;

  // Sideband that travels with each transaction: a typed-in expectation, if any.
  logic                     row_typed  = 1'b0;
  logic [ST_W-1:0]          row_status = ST_OK;
  logic signed [DATA_W-1:0] row_data   = '0;
  logic [LEN_W-1:0]         row_length = '0;

  // List model state: contents and element count.
  logic signed [DATA_W-1:0] list_mem [LIST_CAP];
  int                       list_len = 0;

  // Results of the latest transaction, filled by the list model.
  list_result_t             list_results [LIST_CAP];
  int                       n_list_results;

  // Results still owed by the DUT, oldest first.
  list_result_t             pending_results [$];
  int                       error_count = 0;

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  positional_list_insert_delete_core #(
    .CAPACITY(LIST_CAP)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .operation_i(operation_i),
    .position_i (position_i),
    .value_i    (value_i),
    .strobe_o   (strobe_o),
    .status_o   (status_o),
    .data_o     (data_o),
    .length_o   (length_o),
    .last_o     (last_o)
  );

  // ---------------------------------------------------------------------------
  // List model
  // ---------------------------------------------------------------------------

  // Length is taken after the state update, so call this once the list is settled.
  function automatic void add_list_result(logic [ST_W-1:0] st, logic signed [DATA_W-1:0] d,
                                          logic lst);
    list_results[n_list_results] = list_result_t'{st, d, list_len[LEN_W-1:0], lst};
    n_list_results++;
  endfunction

  function automatic void apply_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                                        logic signed [DATA_W-1:0] val);
    int                       p;
    int                       i;
    logic signed [DATA_W-1:0] removed;
    p = int'(pos);
    n_list_results = 0;
    case (op)
      OP_INSERT: begin
        // position is checked before capacity
        if (p == 0 || p > list_len + 1) begin
          add_list_result(ST_BADPOS, '0, 1'b1);
        end else if (list_len >= LIST_CAP) begin
          add_list_result(ST_FULL, '0, 1'b1);
        end else begin
          for (i = list_len; i > p - 1; i--) list_mem[i] = list_mem[i-1];
          list_mem[p-1] = val;
          list_len++;
          add_list_result(ST_OK, val, 1'b1);
        end
      end
      OP_DELETE: begin
        // empty is checked before position
        if (list_len == 0) begin
          add_list_result(ST_UNDERFLOW, '0, 1'b1);
        end else if (p == 0 || p > list_len) begin
          add_list_result(ST_BADPOS, '0, 1'b1);
        end else begin
          removed = list_mem[p-1];
          for (i = p - 1; i + 1 < list_len; i++) list_mem[i] = list_mem[i+1];
          list_len--;
          add_list_result(ST_OK, removed, 1'b1);
        end
      end
      OP_DISPLAY: begin
        if (list_len == 0) begin
          add_list_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (i = 0; i < list_len; i++) add_list_result(ST_OK, list_mem[i], i + 1 == list_len);
        end
      end
      default: begin
        add_list_result(ST_BADPOS, '0, 1'b1);
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("ERROR @%0t: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    error_count++;
  endtask

  // Everything is sampled at the rising edge, before the DUT's own updates land.
  // A result still showing and a new transaction may both happen at one edge; the
  // result belongs to the older transaction, so it is checked first.
  always @(posedge clk_i) begin
    list_result_t owed;
    if (rst_ni) begin
      if (strobe_o) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing outstanding, status", 64'(status_o), 64'h0);
        end else begin
          owed = pending_results.pop_front();
          if (status_o !== owed.status)
            report_mismatch("status", 64'(status_o), 64'(owed.status));
          if (data_o !== owed.data)
            report_mismatch("data", 64'(unsigned'(data_o)), 64'(unsigned'(owed.data)));
          if (length_o !== owed.length)
            report_mismatch("length", 64'(length_o), 64'(owed.length));
          if (last_o !== owed.last)
            report_mismatch("last", 64'(last_o), 64'(owed.last));
        end
      end
      if (start && !busy) begin
        // the model always runs so its state tracks the DUT, typed rows included
        apply_list_op(operation_i, position_i, value_i);
        if (row_typed) begin
          pending_results.push_back(list_result_t'{row_status, row_data, row_length, 1'b1});
        end else begin
          for (int k = 0; k < n_list_results; k++) pending_results.push_back(list_results[k]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Mostly back to back or short, now and then a long pause.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic idle_cycles(int n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  // Present one transaction and hold it until the DUT takes it.
  task automatic issue_list_op(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                               logic signed [DATA_W-1:0] val, logic typed,
                               logic [ST_W-1:0] st, logic signed [DATA_W-1:0] d,
                               logic [LEN_W-1:0] len);
    operation_i <= op;
    position_i  <= pos;
    value_i     <= val;
    row_typed   <= typed;
    row_status  <= st;
    row_data    <= d;
    row_length  <= len;
    start       <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
  endtask

  initial begin
    int                       sent;
    int                       burst;
    int                       mode;
    int                       roll;
    int                       lenv;
    bit                       calm;
    logic [OP_W-1:0]          op;
    logic [POS_W-1:0]         pos;
    logic signed [DATA_W-1:0] val;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    for (int r = 0; r < N_DIRECTED; r++) begin
      idle_cycles(pick_gap());
      issue_list_op(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].pos, DIRECTED_ROWS[r].val,
                    DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].status,
                    DIRECTED_ROWS[r].data, DIRECTED_ROWS[r].length);
    end

    // Random bursts. Fill bursts push the list to capacity (full errors, 16-element
    // displays), drain bursts pull it back to empty; mixed bursts hover in between.
    // Some bursts run with no idling at all.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      mode  = $urandom_range(0, 2);
      burst = $urandom_range(15, 40);
      calm  = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        // count may lag one transaction behind; it only shapes positions
        lenv = list_len;
        roll = $urandom_range(0, 99);
        val  = $signed($urandom);
        if (roll < 8) begin
          // noise: any opcode, any position
          op  = OP_W'($urandom_range(0, 3));
          pos = POS_W'($urandom_range(0, 31));
        end else begin
          roll = $urandom_range(0, 99);
          case (mode)
            0:       op = (roll < 80) ? OP_INSERT : (roll < 90) ? OP_DELETE : OP_DISPLAY;
            1:       op = (roll < 80) ? OP_DELETE : (roll < 90) ? OP_INSERT : OP_DISPLAY;
            default: op = (roll < 38) ? OP_INSERT : (roll < 76) ? OP_DELETE : OP_DISPLAY;
          endcase
          if (op == OP_INSERT) pos = POS_W'($urandom_range(1, lenv + 1));
          else if (op == OP_DELETE) pos = POS_W'($urandom_range(1, (lenv > 0) ? lenv : 1));
          else pos = POS_W'($urandom_range(0, 31));
        end
        if (!calm) idle_cycles(pick_gap());
        issue_list_op(op, pos, val, 1'b0, ST_OK, '0, '0);
        sent++;
      end
    end
    start <= 1'b0;

    // Drain outstanding results, then watch for strays.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (LIST_CAP + 8) @(posedge clk_i);

    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/plist_pkg.sv
sv/plist_ram.sv
sv/positional_list_insert_delete_core.sv
tb/sv/tb.sv
